[rtl/core/stbs_pkg.sv]
`timescale 1ns / 1ps

package stbs_pkg;

  localparam int WORD_W     = 32;
  localparam int SLOT_W     = 10;
  localparam int POS_W      = 10;
  localparam int LEN_W      = 11;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [LEN_W-1:0] LEN_RESET = 11'd1024;

  // register index: paddr bits above the byte offset
  localparam logic REG_USED_LENGTH = 1'b0;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BOUND_LO,
    ST_BOUND_HI,
    ST_PROBE,
    ST_DONE
  } state_t;

endpackage

[rtl/core/stbs_mem.sv]
`timescale 1ns / 1ps

module stbs_mem
  import stbs_pkg::*;
#(
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WORD_W-1:0]        wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WORD_W-1:0]        rdata
);

  logic [WORD_W-1:0] ram [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      ram[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= ram[raddr];
    end
  end

endmodule

[rtl/core/stbs_ctrl.sv]
`timescale 1ns / 1ps

module stbs_ctrl
  import stbs_pkg::*;
#(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic                           in_op,
  input  logic [SLOT_W-1:0]              in_slot,
  input  logic [WORD_W-1:0]              in_word,
  input  logic [LEN_W-1:0]               used_length,
  output logic                           mem_we,
  output logic [$clog2(TABLE_DEPTH)-1:0] mem_waddr,
  output logic [WORD_W-1:0]              mem_wdata,
  output logic                           mem_re,
  output logic [$clog2(TABLE_DEPTH)-1:0] mem_raddr,
  input  logic [WORD_W-1:0]              mem_rdata,
  output logic                           out_valid,
  output logic                           out_found,
  output logic [POS_W-1:0]               out_position
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int LW = AW + 1;

  state_t                    state_r, state_nxt;
  logic signed [WORD_W-1:0]  key_r, key_nxt;
  logic [LW-1:0]             n_r, n_nxt;
  logic [LW-1:0]             lo_r, lo_nxt;
  logic [LW-1:0]             hi_r, hi_nxt;
  logic [LW-1:0]             mid_r, mid_nxt;
  logic                      lo_ok_r, lo_ok_nxt;
  logic                      found_r, found_nxt;
  logic [POS_W-1:0]          pos_r, pos_nxt;

  logic signed [WORD_W-1:0]  entry;
  logic [LW-1:0]             lo_step, hi_step;

  assign entry = $signed(mem_rdata);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    n_r     <= n_nxt;
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    mid_r   <= mid_nxt;
    lo_ok_r <= lo_ok_nxt;
    found_r <= found_nxt;
    pos_r   <= pos_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    key_nxt   = key_r;
    n_nxt     = n_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    mid_nxt   = mid_r;
    lo_ok_nxt = lo_ok_r;
    found_nxt = found_r;
    pos_nxt   = pos_r;
    lo_step   = lo_r;
    hi_step   = hi_r;
    mem_we    = 1'b0;
    mem_waddr = AW'(in_slot);
    mem_wdata = in_word;
    mem_re    = 1'b0;
    mem_raddr = '0;
    busy      = (state_r != ST_IDLE);
    out_valid = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (in_op == OP_WRITE) begin
            mem_we = (int'(in_slot) < TABLE_DEPTH);
          end else begin
            key_nxt   = $signed(in_word);
            found_nxt = 1'b0;
            pos_nxt   = '0;
            if (int'(used_length) > TABLE_DEPTH) begin
              n_nxt = LW'(TABLE_DEPTH);
            end else begin
              n_nxt = LW'(used_length);
            end
            if (used_length == '0) begin
              state_nxt = ST_DONE;
            end else begin
              mem_re    = 1'b1;
              mem_raddr = '0;
              state_nxt = ST_BOUND_LO;
            end
          end
        end
      end
      ST_BOUND_LO: begin
        // first entry arrives; fetch last used entry
        lo_ok_nxt = (key_r >= entry);
        mem_re    = 1'b1;
        mem_raddr = AW'(n_r - LW'(1));
        state_nxt = ST_BOUND_HI;
      end
      ST_BOUND_HI: begin
        if (lo_ok_r && (key_r <= entry)) begin
          lo_nxt    = '0;
          hi_nxt    = n_r;
          mid_nxt   = n_r >> 1;
          mem_re    = 1'b1;
          mem_raddr = mid_nxt[AW-1:0];
          state_nxt = ST_PROBE;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_PROBE: begin
        // compare the probe and issue the next one in the same cycle
        if (key_r == entry) begin
          found_nxt = 1'b1;
          pos_nxt   = POS_W'(mid_r);
          state_nxt = ST_DONE;
        end else begin
          if (key_r < entry) begin
            hi_step = mid_r;
          end else begin
            lo_step = mid_r + LW'(1);
          end
          lo_nxt  = lo_step;
          hi_nxt  = hi_step;
          mid_nxt = lo_step + ((hi_step - lo_step) >> 1);
          if (lo_step < hi_step) begin
            mem_re    = 1'b1;
            mem_raddr = mid_nxt[AW-1:0];
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        out_valid = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_found    = found_r;
  assign out_position = pos_r;

endmodule

[rtl/core/sorted_table_binary_search.sv]
`timescale 1ns / 1ps
// Channel | Ports                                         | Handshake
// input   | in_op, in_slot, in_word                       | start & !busy
// result  | out_found, out_position                       | out_valid, one cycle
// config  | cfg_psel/penable/pwrite/paddr/pwdata/prdata   | APB, pready tied high
//
// A write item produces no result; busy stays low. A search item keeps busy
// high through the bound checks, P probes (at most floor(log2(n)) + 1,
// 11 for 1024 entries) and the result, which carries out_valid.
// Keys outside the first/last entry bounds skip the probes.
// The single read port of the table memory sets the pace: one probe a cycle.
// Synchronous reset returns to idle; table contents are not cleared.
// The result receiver cannot stall; no holding is needed.

module sorted_table_binary_search
  import stbs_pkg::*;
#(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_op,
  input  logic [SLOT_W-1:0]     in_slot,
  input  logic [WORD_W-1:0]     in_word,
  output logic                  out_valid,
  output logic                  out_found,
  output logic [POS_W-1:0]      out_position,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  localparam int AW = $clog2(TABLE_DEPTH);

  logic [LEN_W-1:0]  used_length_r;
  logic              reg_sel;
  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [WORD_W-1:0] mem_wdata, mem_rdata;

  assign cfg_pready = 1'b1;
  assign reg_sel    = (cfg_paddr[CFG_ADDR_W-1] == REG_USED_LENGTH);
  assign cfg_prdata = reg_sel ? CFG_DATA_W'(used_length_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_length_r <= LEN_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && reg_sel) begin
      used_length_r <= cfg_pwdata[LEN_W-1:0];
    end
  end

  stbs_ctrl #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_op       (in_op),
    .in_slot     (in_slot),
    .in_word     (in_word),
    .used_length (used_length_r),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_re      (mem_re),
    .mem_raddr   (mem_raddr),
    .mem_rdata   (mem_rdata),
    .out_valid   (out_valid),
    .out_found   (out_found),
    .out_position(out_position)
  );

  // writes are taken only when idle and reads only during a search: no overlap
  stbs_mem #(
    .DEPTH(TABLE_DEPTH)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

endmodule

[rtl/core/stbs_chk.sv]
`timescale 1ns / 1ps

module stbs_chk
  import stbs_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  start,
  input logic                  busy,
  input logic                  in_op,
  input logic                  out_valid,
  input logic                  out_found,
  input logic [POS_W-1:0]      out_position
);

  // a result only ends a search in progress
  a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result shown while idle");

  // after a result the block is free for the next item
  a_free_after: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> (!busy && !out_valid))
    else $error("block still busy after result");

  // a miss reports position zero
  a_miss_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> (out_position == '0))
    else $error("miss with nonzero position");

  // only an accepted search makes the block busy
  a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> ($past(start) && ($past(in_op) == OP_SEARCH)))
    else $error("busy without a search item");

endmodule

bind sorted_table_binary_search stbs_chk u_stbs_chk (.*);

[tb/sorted_table_binary_search_tb.sv]
`timescale 1ns / 1ps

module sorted_table_binary_search_tb;
  import stbs_pkg::*;

  localparam int TABLE_DEPTH = 1024;
  localparam int CYCLE_LIMIT = 400000;
  // longest search: the bound checks, all probes and the result, with margin
  localparam int SETTLE_CYCLES = 20;
  localparam int RANDOM_ITEMS = 470;

  localparam logic [WORD_W-1:0] WORD_MIN = 32'h8000_0000;
  localparam logic [WORD_W-1:0] WORD_MAX = 32'h7FFF_FFFF;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
  } search_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic                  in_op = OP_WRITE;
  logic [SLOT_W-1:0]     in_slot = '0;
  logic [WORD_W-1:0]     in_word = '0;
  logic                  out_valid;
  logic                  out_found;
  logic [POS_W-1:0]      out_position;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  // shadow copy of the table and the length register
  logic signed [WORD_W-1:0] shadow_table [TABLE_DEPTH];
  logic [LEN_W-1:0]         shadow_length = LEN_RESET;

  search_result_t pending_results [$];
  search_result_t oldest_result;
  int             mismatch_count = 0;
  int             items_sent = 0;
  int             cycle_count = 0;
  bit             burst_mode = 1'b0;

  sorted_table_binary_search #(.TABLE_DEPTH(TABLE_DEPTH)) uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_op        (in_op),
    .in_slot      (in_slot),
    .in_word      (in_word),
    .out_valid    (out_valid),
    .out_found    (out_found),
    .out_position (out_position),
    .cfg_psel     (cfg_psel),
    .cfg_penable  (cfg_penable),
    .cfg_pwrite   (cfg_pwrite),
    .cfg_paddr    (cfg_paddr),
    .cfg_pwdata   (cfg_pwdata),
    .cfg_prdata   (cfg_prdata),
    .cfg_pready   (cfg_pready)
  );

  always #5 clk = ~clk;

  function automatic search_result_t predict_search(input logic signed [WORD_W-1:0] key);
    search_result_t res;
    int n, lo, hi, mid;
    res = '0;
    n = int'(shadow_length);
    if (n > TABLE_DEPTH) n = TABLE_DEPTH;
    if (n > 0 && key >= shadow_table[0] && key <= shadow_table[n-1]) begin
      lo = 0;
      hi = n;
      while (lo < hi) begin
        mid = lo + (hi - lo) / 2;
        if (key == shadow_table[mid]) begin
          res.found = 1'b1;
          res.position = POS_W'(mid);
          break;
        end else if (key < shadow_table[mid]) begin
          hi = mid;
        end else begin
          lo = mid + 1;
        end
      end
    end
    return res;
  endfunction

  task automatic issue_item(input logic op, input logic [SLOT_W-1:0] slot,
                            input logic [WORD_W-1:0] word);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_op   <= op;
    in_slot <= slot;
    in_word <= word;
    do @(posedge clk); while (busy !== 1'b0);
    if (op == OP_WRITE) begin
      shadow_table[slot] = word;
    end else begin
      pending_results.push_back(predict_search(word));
    end
    items_sent++;
  endtask

  task automatic search_key(input logic [WORD_W-1:0] key);
    issue_item(OP_SEARCH, SLOT_W'($urandom), key);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    // writes leave no result, so let any trailing work finish
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_used_length(input logic [LEN_W-1:0] value);
    logic [CFG_ADDR_W-1:0] addr;
    addr = {REG_USED_LENGTH, 2'b00};
    wait_drained();
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= CFG_DATA_W'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    shadow_length = value;
    // read it back
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    if (cfg_prdata[LEN_W-1:0] !== value) begin
      $error("used_length readback: expected %0d, got %0d", value, cfg_prdata[LEN_W-1:0]);
      mismatch_count++;
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // non-decreasing run of random values in slots 0..count-1
  task automatic fill_sorted(input int count);
    longint value;
    int     i, step_kind;
    value = longint'($signed($urandom)) / 2;
    step_kind = $urandom_range(0, 2);
    for (i = 0; i < count; i++) begin
      issue_item(OP_WRITE, SLOT_W'(i), value[WORD_W-1:0]);
      case (step_kind)
        0:       value += $urandom_range(0, 2);
        1:       value += $urandom_range(1, 1000);
        default: value += $urandom_range(1, 1 << 24);
      endcase
      if (value > 64'sd2147483647) value = 64'sd2147483647;
    end
  endtask

  function automatic logic [WORD_W-1:0] pick_key(input int n);
    logic [WORD_W-1:0] entry;
    int sel;
    if (n > TABLE_DEPTH) n = TABLE_DEPTH;
    if (n == 0) return $urandom;
    entry = shadow_table[$urandom_range(0, n - 1)];
    sel = $urandom_range(0, 9);
    case (sel)
      0, 1, 2, 3, 4: return entry;
      5:             return entry + 1;
      6:             return entry - 1;
      7:             return $urandom_range(0, 1) ? WORD_MIN : WORD_MAX;
      default:       return $urandom;
    endcase
  endfunction

  // whole table sorted, searched at the reset length
  task automatic test_reset_length();
    int i;
    for (i = 0; i < TABLE_DEPTH - 1; i++)
      issue_item(OP_WRITE, SLOT_W'(i), WORD_MIN + WORD_W'(i) * 32'h0040_0000 + WORD_W'(i));
    issue_item(OP_WRITE, SLOT_W'(TABLE_DEPTH - 1), WORD_MAX);
    search_key(WORD_MIN);
    search_key(WORD_MAX);
    search_key(shadow_table[511]);
    search_key(shadow_table[512]);
    search_key(shadow_table[300] + 1);
    search_key(shadow_table[1022] + 5);
  endtask

  task automatic test_oversized_length();
    set_used_length(11'd1025);
    search_key(WORD_MAX);
    search_key(shadow_table[700]);
    set_used_length(11'd2047);
    search_key(WORD_MIN);
    search_key(shadow_table[1]);
  endtask

  task automatic test_bound_checks();
    set_used_length(11'd5);
    issue_item(OP_WRITE, 10'd0, -32'sd100);
    issue_item(OP_WRITE, 10'd1, -32'sd50);
    issue_item(OP_WRITE, 10'd2, 32'sd0);
    issue_item(OP_WRITE, 10'd3, 32'sd50);
    issue_item(OP_WRITE, 10'd4, 32'sd100);
    search_key(-32'sd101);
    search_key(32'sd101);
    search_key(-32'sd100);
    search_key(32'sd100);
    search_key(32'sd50);
    search_key(32'sd25);
    search_key(WORD_MIN);
    search_key(WORD_MAX);
  endtask

  task automatic test_single_entry();
    set_used_length(11'd1);
    search_key(-32'sd100);
    search_key(-32'sd99);
  endtask

  task automatic test_empty_length();
    set_used_length(11'd0);
    search_key(-32'sd100);
    search_key(32'sd0);
  endtask

  // probe path still followed on an unsorted table
  task automatic test_unsorted_table();
    int i;
    int vals [8] = '{5, 40, 10, 30, 20, 60, 50, 70};
    set_used_length(11'd8);
    for (i = 0; i < 8; i++) issue_item(OP_WRITE, SLOT_W'(i), WORD_W'(vals[i]));
    search_key(32'd30);
    search_key(32'd20);
    search_key(32'd40);
    search_key(32'd60);
  endtask

  task automatic test_duplicate_entries();
    int i;
    set_used_length(11'd6);
    for (i = 0; i < 6; i++) issue_item(OP_WRITE, SLOT_W'(i), 32'd77);
    search_key(32'd77);
    search_key(32'd76);
    search_key(32'd78);
  endtask

  task automatic test_random_traffic();
    int first_item, sel, n, n_eff, k, count;
    logic [LEN_W-1:0] len;
    first_item = items_sent;
    while (items_sent - first_item < RANDOM_ITEMS) begin
      sel = $urandom_range(0, 19);
      case (sel)
        0:       len = 11'd0;
        1:       len = LEN_W'($urandom_range(1025, 2047));
        2, 3:    len = 11'd1024;
        4, 5:    len = LEN_W'($urandom_range(65, 1023));
        default: len = LEN_W'($urandom_range(1, 64));
      endcase
      set_used_length(len);
      burst_mode = ($urandom_range(0, 3) == 0);
      n = int'(len);
      n_eff = (n > TABLE_DEPTH) ? TABLE_DEPTH : n;
      if (n_eff > 0 && n_eff <= 64) fill_sorted(n_eff);
      count = $urandom_range(10, 30);
      for (k = 0; k < count; k++) begin
        if ($urandom_range(0, 9) == 0)
          issue_item(OP_WRITE, SLOT_W'($urandom), $urandom);
        else
          search_key(pick_key(n_eff));
      end
      burst_mode = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      if (pending_results.size() == 0) begin
        $error("search result with no search pending: found %0d position %0d",
               out_found, out_position);
        mismatch_count++;
      end else begin
        oldest_result = pending_results.pop_front();
        if (out_found !== oldest_result.found) begin
          $error("found: expected %0d, got %0d", oldest_result.found, out_found);
          mismatch_count++;
        end
        if (out_position !== oldest_result.position) begin
          $error("position: expected %0d, got %0d", oldest_result.position, out_position);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("sorted_table_binary_search verification failed");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_length();
    test_oversized_length();
    test_bound_checks();
    test_single_entry();
    test_empty_length();
    test_unsorted_table();
    test_duplicate_entries();
    test_random_traffic();
    wait_drained();
    if (mismatch_count == 0) begin
      $display("sorted_table_binary_search verification clean");
    end else begin
      $display("sorted_table_binary_search verification failed");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/stbs_pkg.sv
rtl/core/stbs_mem.sv
rtl/core/stbs_ctrl.sv
rtl/core/sorted_table_binary_search.sv
rtl/core/stbs_chk.sv
tb/sorted_table_binary_search_tb.sv
